// ===== rtl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Shared widths, stage indexes and types of the triangle scanline span block.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int COORD_W     = 16;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int MAG_W       = 2 * COORD_W;
    localparam int QUO_W       = COORD_W;
    localparam int DIV_STEPS   = QUO_W;
    localparam int FRAC_SCALE  = 16;
    localparam int NUM_LANES   = 3;

    localparam int ST_PRE      = 0;
    localparam int ST_MUL      = 1;
    localparam int ST_ABS      = 2;
    localparam int ST_DIV0     = 3;
    localparam int ST_FIX      = ST_DIV0 + DIV_STEPS;
    localparam int ST_OUT      = ST_FIX + 1;
    localparam int PIPE_DEPTH  = ST_OUT + 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic        [MAG_W-1:0]   t_mag;
    typedef logic        [QUO_W-1:0]   t_quo;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] load;
    } t_pipe_ctl;

endpackage

// ===== rtl/tss_if.sv =====
// ----------------------------------------------------------------------------
// tss_tri_if / tss_span_if
// Valid/ready channels for triangle beats in and span beats out.
// ----------------------------------------------------------------------------
interface tss_tri_if;
    logic            valid;
    logic            ready;
    tss_pkg::t_coord vertex_a_x;
    tss_pkg::t_coord vertex_a_y;
    tss_pkg::t_coord vertex_b_x;
    tss_pkg::t_coord vertex_b_y;
    tss_pkg::t_coord vertex_c_x;
    tss_pkg::t_coord vertex_c_y;
    tss_pkg::t_coord scan_y;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, scan_y,
        input  ready
    );
    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, scan_y,
        output ready
    );
endinterface

interface tss_span_if;
    logic            valid;
    logic            ready;
    logic            span_valid;
    tss_pkg::t_coord span_left;
    tss_pkg::t_coord span_right;

    modport source (
        output valid, span_valid, span_left, span_right,
        input  ready
    );
    modport sink (
        input  valid, span_valid, span_left, span_right,
        output ready
    );
endinterface

// ===== rtl/tss_pipe_ctl.sv =====
// ----------------------------------------------------------------------------
// tss_pipe_ctl
// Per-stage valid bits and load enables; bubbles collapse under stall.
// ----------------------------------------------------------------------------
module tss_pipe_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output tss_pkg::t_pipe_ctl o_ctl
);
    import tss_pkg::*;

    localparam logic [PIPE_DEPTH-1:0] PIPE_ONE = PIPE_DEPTH'(1);

    logic [PIPE_DEPTH-1:0] r_valid;
    logic [PIPE_DEPTH-1:0] n_valid;
    logic [PIPE_DEPTH-1:0] load;
    logic                  accept;
    logic                  deliver;

    // a stage may load when the output drains or some stage at or after it is empty
    always_comb begin
        for (int k = 0; k < PIPE_DEPTH; k++) begin
            load[k] = i_out_ready || !(&(r_valid | ((PIPE_ONE << k) - PIPE_ONE)));
        end
    end

    always_comb begin
        n_valid[0] = load[0] ? i_in_valid : r_valid[0];
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            n_valid[k] = load[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ctl.load  = load;
    assign o_in_ready  = load[0];
    assign o_out_valid = r_valid[PIPE_DEPTH-1];
    assign accept      = i_in_valid && load[0];
    assign deliver     = r_valid[PIPE_DEPTH-1] && i_out_ready;

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[PIPE_DEPTH-1] |-> o_in_ready)
        else $error("input stalled with empty output stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_valid[0])
        else $error("accepted beat not captured");

    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ($countones(r_valid) == $past($countones(r_valid))
            + int'($past(accept)) - int'($past(deliver))))
        else $error("beat lost or duplicated in pipeline");

endmodule

// ===== rtl/tss_edge_lane.sv =====
// ----------------------------------------------------------------------------
// tss_edge_lane
// One edge: half-open hit test, product, restoring divide, crossing x.
// ----------------------------------------------------------------------------
module tss_edge_lane (
    input  logic               i_clk,
    input  tss_pkg::t_pipe_ctl i_ctl,
    input  logic               i_line_ok,
    input  tss_pkg::t_coord    i_xa,
    input  tss_pkg::t_coord    i_ya,
    input  tss_pkg::t_coord    i_xb,
    input  tss_pkg::t_coord    i_yb,
    input  tss_pkg::t_coord    i_y,
    output logic               o_hit,
    output tss_pkg::t_coord    o_x
);
    import tss_pkg::*;

    logic   hit;
    logic   r_pre_hit;
    t_diff  r_dy;
    t_diff  r_dx;
    t_diff  r_den;
    t_coord r_pre_xa;

    logic   r_mul_hit;
    t_prod  r_prod;
    t_diff  r_mul_den;
    t_coord r_mul_xa;

    t_prod  prod_neg;
    t_diff  den_neg;

    t_mag   r_rem [DIV_STEPS+1];
    t_quo   r_quo [DIV_STEPS+1];
    t_quo   r_dvs [DIV_STEPS+1];
    logic   r_neg [DIV_STEPS+1];
    logic   r_hit [DIV_STEPS+1];
    t_coord r_xa  [DIV_STEPS+1];

    t_diff  quo_ext;
    t_diff  quo_signed;
    logic   r_fix_hit;
    t_coord r_x;

    assign hit = i_line_ok && (((i_ya <= i_y) && (i_yb > i_y)) ||
                               ((i_yb <= i_y) && (i_ya > i_y)));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_PRE]) begin
            r_pre_hit <= hit;
            r_dy      <= t_diff'(i_y)  - t_diff'(i_ya);
            r_dx      <= t_diff'(i_xb) - t_diff'(i_xa);
            r_den     <= t_diff'(i_yb) - t_diff'(i_ya);
            r_pre_xa  <= i_xa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_MUL]) begin
            r_mul_hit <= r_pre_hit;
            r_prod    <= t_prod'(r_dy) * t_prod'(r_dx);
            r_mul_den <= r_den;
            r_mul_xa  <= r_pre_xa;
        end
    end

    assign prod_neg = -r_prod;
    assign den_neg  = -r_mul_den;

    // magnitudes; quotient sign is set back after the divide
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_ABS]) begin
            r_rem[0] <= r_prod[PROD_W-1] ? prod_neg[MAG_W-1:0] : r_prod[MAG_W-1:0];
            r_dvs[0] <= r_mul_den[DIFF_W-1] ? den_neg[QUO_W-1:0] : r_mul_den[QUO_W-1:0];
            r_quo[0] <= '0;
            r_neg[0] <= r_prod[PROD_W-1] ^ r_mul_den[DIFF_W-1];
            r_hit[0] <= r_mul_hit;
            r_xa[0]  <= r_mul_xa;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int BIT = QUO_W - 1 - k;
        t_mag trial;
        logic fits;

        assign trial = t_mag'(r_dvs[k]) << BIT;
        assign fits  = r_rem[k] >= trial;

        always_ff @(posedge i_clk) begin
            if (i_ctl.load[ST_DIV0+k]) begin
                r_rem[k+1] <= fits ? r_rem[k] - trial : r_rem[k];
                r_quo[k+1] <= r_quo[k] | (t_quo'(fits) << BIT);
                r_dvs[k+1] <= r_dvs[k];
                r_neg[k+1] <= r_neg[k];
                r_hit[k+1] <= r_hit[k];
                r_xa[k+1]  <= r_xa[k];
            end
        end
    end

    assign quo_ext    = t_diff'({1'b0, r_quo[DIV_STEPS]});
    assign quo_signed = r_neg[DIV_STEPS] ? -quo_ext : quo_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_FIX]) begin
            r_fix_hit <= r_hit[DIV_STEPS];
            r_x       <= r_xa[DIV_STEPS] + quo_signed[COORD_W-1:0];
        end
    end

    assign o_hit = r_fix_hit;
    assign o_x   = r_x;

endmodule

// ===== rtl/tss_span_merge.sv =====
// ----------------------------------------------------------------------------
// tss_span_merge
// Pair the two crossed edges, order them and hold the span beat.
// ----------------------------------------------------------------------------
module tss_span_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tss_pkg::t_pipe_ctl            i_ctl,
    input  logic                          i_out_valid,
    input  logic [tss_pkg::NUM_LANES-1:0] i_hit,
    input  tss_pkg::t_coord               i_x [tss_pkg::NUM_LANES],
    output logic                          o_span_valid,
    output tss_pkg::t_coord               o_left,
    output tss_pkg::t_coord               o_right
);
    import tss_pkg::*;

    logic   pair_ok;
    t_coord xp;
    t_coord xq;
    logic   r_span_valid;
    t_coord r_left;
    t_coord r_right;

    always_comb begin
        pair_ok = 1'b1;
        xp      = i_x[0];
        xq      = i_x[1];
        case (i_hit)
            3'b011: begin
                xp = i_x[0];
                xq = i_x[1];
            end
            3'b110: begin
                xp = i_x[1];
                xq = i_x[2];
            end
            3'b101: begin
                xp = i_x[2];
                xq = i_x[0];
            end
            default: begin
                pair_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_OUT]) begin
            r_span_valid <= pair_ok;
            r_left       <= !pair_ok ? '0 : ((xp <= xq) ? xp : xq);
            r_right      <= !pair_ok ? '0 : ((xp <= xq) ? xq : xp);
        end
    end

    assign o_span_valid = r_span_valid;
    assign o_left       = r_left;
    assign o_right      = r_right;

    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && r_span_valid) |-> (r_left <= r_right))
        else $error("span ends out of order");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !r_span_valid) |-> (r_left == '0 && r_right == '0))
        else $error("empty span carries nonzero ends");

endmodule

// ===== rtl/triangle_scanline_span.sv =====
// ----------------------------------------------------------------------------
// triangle_scanline_span
// Horizontal span a triangle covers on one scanline, Q12.4 coordinates.
//
//   channel   dir   beat contents
//   i_tri     in    vertex_a/b/c x,y and scan_y, signed Q12.4
//   o_span    out   span_valid, span_left, span_right (zero when not valid)
//
// One triangle beat per clock unless a stalled o_span has filled every stage.
// Each beat passes through the lanes: hit test, multiply, magnitude, a 16-stage
// restoring divider (one quotient bit per stage), sign fix, then the merge.
// Synchronous reset clears only the stage valid bits.
// A stall on o_span holds full stages; i_tri.ready drops only when every
// stage holds a beat and the output is not taken.
// ----------------------------------------------------------------------------
module triangle_scanline_span #(
    parameter int SCREEN_LINES = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tss_tri_if.sink   i_tri,
    tss_span_if.source o_span
);
    import tss_pkg::*;

    localparam t_diff LINE_LIMIT = t_diff'(SCREEN_LINES * FRAC_SCALE);

    t_pipe_ctl              ctl;
    logic                   line_ok;
    t_coord                 vx [NUM_LANES];
    t_coord                 vy [NUM_LANES];
    logic [NUM_LANES-1:0]   lane_hit;
    t_coord                 lane_x [NUM_LANES];

    assign line_ok = !i_tri.scan_y[COORD_W-1] && (t_diff'(i_tri.scan_y) <= LINE_LIMIT);

    assign vx[0] = i_tri.vertex_a_x;
    assign vy[0] = i_tri.vertex_a_y;
    assign vx[1] = i_tri.vertex_b_x;
    assign vy[1] = i_tri.vertex_b_y;
    assign vx[2] = i_tri.vertex_c_x;
    assign vy[2] = i_tri.vertex_c_y;

    tss_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_tri.valid),
        .i_out_ready (o_span.ready),
        .o_in_ready  (i_tri.ready),
        .o_out_valid (o_span.valid),
        .o_ctl       (ctl)
    );

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        localparam int NXT = (k + 1) % NUM_LANES;

        tss_edge_lane u_lane (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_line_ok (line_ok),
            .i_xa      (vx[k]),
            .i_ya      (vy[k]),
            .i_xb      (vx[NXT]),
            .i_yb      (vy[NXT]),
            .i_y       (i_tri.scan_y),
            .o_hit     (lane_hit[k]),
            .o_x       (lane_x[k])
        );
    end

    tss_span_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_out_valid  (o_span.valid),
        .i_hit        (lane_hit),
        .i_x          (lane_x),
        .o_span_valid (o_span.span_valid),
        .o_left       (o_span.span_left),
        .o_right      (o_span.span_right)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for triangle_scanline_span. A directed table covers
// off-screen lines, the last visible line, flat triangles, lines through
// vertices and extreme coordinates; random triangles follow, mostly around
// the scanline with random content, some fully random. Every span beat is checked
// field by field against an in-bench span predictor (typed rows: an empty span),
// under random idling on both channels and one long output stall that backs up the pipe.
// ----------------------------------------------------------------------------
module tb;
    import tss_pkg::*;

    localparam int SCREEN_LINES = 1024;
    localparam int PX           = FRAC_SCALE;
    localparam int LONG_HOLD    = 300;
    localparam int CHUNKS       = 13;
    localparam int CHUNK_ITEMS  = 100;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
        t_coord cx;
        t_coord cy;
        t_coord sy;
    } t_tri_beat;

    typedef struct packed {
        logic   ok;
        t_coord left;
        t_coord right;
    } t_span_beat;

    typedef struct packed {
        t_tri_beat  tri_in;
        logic       typed;
        t_span_beat want;
    } t_dir_row;

    logic clk;
    logic rst_n;

    tss_tri_if  tri_ch ();
    tss_span_if span_ch ();

    t_span_beat pending_spans[$];
    t_dir_row   directed_rows[$];
    int         fault_count = 0;
    bit         tx_idle     = 1'b1;
    bit         rx_idle     = 1'b1;
    bit         hold_output = 1'b0;

    triangle_scanline_span #(
        .SCREEN_LINES(SCREEN_LINES)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tri   (tri_ch),
        .o_span  (span_ch)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void report_fault(input string what);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("%s", what);
    endfunction

    function automatic bit edge_crossing(input longint xa, input longint ya,
                                         input longint xb, input longint yb,
                                         input longint y, output longint x);
        x = 0;
        if ((ya <= y && yb > y) || (yb <= y && ya > y)) begin
            x = xa + ((y - ya) * (xb - xa)) / (yb - ya);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_span_beat predict_span(input t_tri_beat t);
        longint     xs[3];
        longint     ax, ay, bx, by, cx, cy, y, px, tmp;
        int         hits;
        t_span_beat s;
        s    = '0;
        hits = 0;
        ax   = longint'($signed(t.ax));
        ay   = longint'($signed(t.ay));
        bx   = longint'($signed(t.bx));
        by   = longint'($signed(t.by));
        cx   = longint'($signed(t.cx));
        cy   = longint'($signed(t.cy));
        y    = longint'($signed(t.sy));
        if (y >= 0 && y <= longint'(SCREEN_LINES) * PX) begin
            if (edge_crossing(ax, ay, bx, by, y, px)) begin
                xs[hits] = px;
                hits++;
            end
            if (edge_crossing(bx, by, cx, cy, y, px)) begin
                xs[hits] = px;
                hits++;
            end
            if (edge_crossing(cx, cy, ax, ay, y, px)) begin
                xs[hits] = px;
                hits++;
            end
            if (hits >= 2) begin
                for (int i = 0; i < hits - 1; i++) begin
                    for (int j = 0; j < hits - 1 - i; j++) begin
                        if (xs[j] > xs[j + 1]) begin
                            tmp       = xs[j];
                            xs[j]     = xs[j + 1];
                            xs[j + 1] = tmp;
                        end
                    end
                end
                s.ok    = 1'b1;
                s.left  = t_coord'(xs[0]);
                s.right = t_coord'(xs[1]);
            end
        end
        return s;
    endfunction

    function automatic void add_row(input int ax, input int ay, input int bx,
                                    input int by, input int cx, input int cy,
                                    input int sy, input bit no_span);
        t_dir_row r;
        r.tri_in = '{t_coord'(ax), t_coord'(ay), t_coord'(bx), t_coord'(by),
                     t_coord'(cx), t_coord'(cy), t_coord'(sy)};
        r.typed  = no_span;
        r.want   = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic t_tri_beat random_triangle();
        t_tri_beat t;
        int        kind;
        int        base;
        int        ys[3];
        t.ax = t_coord'($urandom);
        t.ay = t_coord'($urandom);
        t.bx = t_coord'($urandom);
        t.by = t_coord'($urandom);
        t.cx = t_coord'($urandom);
        t.cy = t_coord'($urandom);
        t.sy = t_coord'($urandom);
        kind = $urandom_range(0, 9);
        if (kind <= 1) return t;
        if (kind == 9)
            base = ($urandom_range(0, 1) ? SCREEN_LINES * PX : 0)
                   + int'($urandom_range(0, 32)) - 16;
        else
            base = $urandom_range(0, SCREEN_LINES * PX);
        for (int i = 0; i < 3; i++) ys[i] = base + int'($urandom_range(0, 8192)) - 4096;
        if (kind == 8) ys[$urandom_range(0, 2)] = base;
        if ($urandom_range(0, 1)) begin
            t.ax = t_coord'(int'($urandom_range(0, 8192)) - 4096);
            t.bx = t_coord'(int'($urandom_range(0, 8192)) - 4096);
            t.cx = t_coord'(int'($urandom_range(0, 8192)) - 4096);
        end
        t.ay = t_coord'(ys[0]);
        t.by = t_coord'(ys[1]);
        t.cy = t_coord'(ys[2]);
        t.sy = t_coord'(base);
        return t;
    endfunction

    task automatic send_triangle(input t_tri_beat t, input bit typed,
                                 input t_span_beat want);
        int gap;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            tri_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tri_ch.valid      <= 1'b1;
        tri_ch.vertex_a_x <= t.ax;
        tri_ch.vertex_a_y <= t.ay;
        tri_ch.vertex_b_x <= t.bx;
        tri_ch.vertex_b_y <= t.by;
        tri_ch.vertex_c_x <= t.cx;
        tri_ch.vertex_c_y <= t.cy;
        tri_ch.scan_y     <= t.sy;
        do @(posedge clk); while (!tri_ch.ready);
        pending_spans.push_back(typed ? want : predict_span(t));
    endtask

    task automatic drain_spans();
        tri_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_spans.size() != 0);
    endtask

    // output side: per-beat stalls, plus one long hold on request
    initial begin
        int stall;
        span_ch.ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_output) begin
                span_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_output = 1'b0;
            end
            stall = rx_idle ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                span_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            span_ch.ready <= 1'b1;
            do @(posedge clk); while (!span_ch.valid);
        end
    end

    always @(posedge clk) begin
        t_span_beat got;
        t_span_beat want;
        if (rst_n && span_ch.valid && span_ch.ready) begin
            got = '{span_ch.span_valid, span_ch.span_left, span_ch.span_right};
            if (pending_spans.size() == 0) begin
                report_fault($sformatf("unexpected span beat: valid %0b left %0d right %0d",
                                       got.ok, $signed(got.left), $signed(got.right)));
            end else begin
                want = pending_spans.pop_front();
                if (got.ok !== want.ok || got.left !== want.left
                        || got.right !== want.right)
                    report_fault($sformatf(
                        "span mismatch: expected %0b %0d %0d, got %0b %0d %0d",
                        want.ok, $signed(want.left), $signed(want.right),
                        got.ok, $signed(got.left), $signed(got.right)));
            end
        end
    end

    initial begin
        rst_n             = 1'b0;
        tri_ch.valid      = 1'b0;
        tri_ch.vertex_a_x = '0;
        tri_ch.vertex_a_y = '0;
        tri_ch.vertex_b_x = '0;
        tri_ch.vertex_b_y = '0;
        tri_ch.vertex_c_x = '0;
        tri_ch.vertex_c_y = '0;
        tri_ch.scan_y     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(0, 0, 0, 0, 0, 0, 0, 1);
        add_row(-1, -1, -1, -1, -1, -1, -1, 1);
        add_row(100*PX, 100*PX, 300*PX, 100*PX, 200*PX, 300*PX, -1, 1);
        add_row(500*PX, 0, 100*PX, 300*PX, 900*PX, 600*PX, -16, 1);
        add_row(0, 900*PX, 500*PX, 1100*PX, -100*PX, 1100*PX, 1024*PX + 1, 1);
        add_row(0, 900*PX, 500*PX, 1100*PX, -100*PX, 1100*PX, 1024*PX, 0);
        add_row(-10*PX, -10*PX, 40*PX, -5*PX, 20*PX, 30*PX, 0, 0);
        add_row(-32768, -32768, 32767, 32767, -32768, 32767, -32768, 1);
        add_row(-32768, -32768, 32767, 32767, -32768, 32767, 32767, 1);
        add_row(-32768, -32768, 32767, 32767, -32768, 32767, 8000, 0);
        add_row(32767, -32768, -32768, 32767, 32767, 32767, 0, 0);
        add_row(32767, -32768, -32768, 32767, 32767, 32767, 1024*PX, 0);
        add_row(10*PX, 100*PX, 400*PX, 100*PX, 900*PX, 100*PX, 100*PX, 1);
        add_row(100*PX, 100*PX, 50*PX, 200*PX, 150*PX, 200*PX, 100*PX, 0);
        add_row(100*PX, 100*PX, 50*PX, 200*PX, 150*PX, 200*PX, 200*PX, 1);
        add_row(100*PX, 100*PX, 50*PX, 200*PX, 150*PX, 200*PX, 150*PX, 0);
        add_row(100*PX, 100*PX, 150*PX, 200*PX, 50*PX, 200*PX, 150*PX, 0);
        add_row(0, 0, 300*PX, 100*PX, 100*PX, 200*PX, 100*PX, 0);
        add_row(-7, 1, 5, 23, -33, 40, 17, 0);
        add_row(-2000*PX, 10*PX, -1500*PX, 50*PX, -1900*PX, 90*PX, 40*PX, 0);

        foreach (directed_rows[i])
            send_triangle(directed_rows[i].tri_in, directed_rows[i].typed,
                          directed_rows[i].want);
        drain_spans();

        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            tx_idle = (chunk == 1 || chunk == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_idle = (chunk == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (chunk == 0) begin
                tx_idle = 1'b1;
                rx_idle = 1'b1;
            end
            if (chunk == 5) hold_output = 1'b1;
            if (chunk == 8) drain_spans();
            repeat (CHUNK_ITEMS) send_triangle(random_triangle(), 1'b0, '0);
        end

        drain_spans();
        repeat (40) @(posedge clk);
        if (pending_spans.size() != 0)
            report_fault($sformatf("%0d span beats never arrived", pending_spans.size()));

        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
